// ===== hw/rtl/terminal_cursor_controller_assert.svh =====
// Assertion macros for the terminal cursor controller checker.
// Included by the checker file; needs nothing else.
`ifndef TERMINAL_CURSOR_CONTROLLER_ASSERT_SVH
`define TERMINAL_CURSOR_CONTROLLER_ASSERT_SVH

// antecedent in one cycle implies consequent in the next
`define TCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcc assertion failed");

// antecedent in one cycle implies the signal holds its value in the next
`define TCC_ASSERT_HOLD(lbl, clk, rstn, ante, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> $stable(sig)) \
    else $error("tcc assertion failed");

`endif

// ===== hw/rtl/tcc_pkg.sv =====
// Shared types and codes of the terminal cursor controller.
// No dependencies.
`default_nettype none

package tcc_pkg;

  localparam int unsigned MAX_COLS    = 256;
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned TAB_SPACING = 8;
  localparam int unsigned EV_DEPTH    = 8;

  typedef enum logic [4:0] {
    CMD_PRINT, CMD_CR, CMD_LF, CMD_RLF, CMD_BS, CMD_TAB, CMD_BACKTAB,
    CMD_SETTAB, CMD_CLRTAB, CMD_CLRALLTABS, CMD_MOVETO, CMD_MOVEBY,
    CMD_COL, CMD_ROW, CMD_SAVE, CMD_RESTORE, CMD_REGION, CMD_ORIGIN,
    CMD_ATTR, CMD_RESETTABS
  } cmd_e;

  typedef enum logic [2:0] {
    EV_STATUS, EV_MARK, EV_SCROLL_UP, EV_SCROLL_DN, EV_INSERT, EV_CELL, EV_TAIL
  } ev_kind_e;

  localparam logic [3:0] CFG_COLUMNS   = 4'd0;
  localparam logic [3:0] CFG_ROWS      = 4'd1;
  localparam logic [3:0] CFG_AUTO_WRAP = 4'd2;
  localparam logic [3:0] CFG_INSERT    = 4'd3;

  typedef struct packed {
    ev_kind_e    kind;
    logic [5:0]  row;
    logic [7:0]  col;
    logic [20:0] ch;
    logic [1:0]  width;
  } ev_t;

  function automatic ev_t mk_ev(input ev_kind_e kind, input logic [5:0] row,
                                input logic [7:0] col, input logic [20:0] ch,
                                input logic [1:0] width);
    ev_t e;
    e.kind  = kind;
    e.row   = row;
    e.col   = col;
    e.ch    = ch;
    e.width = width;
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/terminal_cursor_controller.sv =====
// Terminal cursor controller: command stream in, cell-store event stream out.
// Depends on tcc_pkg and tcc_tab_mem.
//
// Usage:
//  s_axis carries one command per transaction (tuser = cmd). m_axis returns
//  the events it causes, in order, ending with a status item flagged by tlast.
//  cfg writes registers: 0 columns, 1 rows in use, 2 auto wrap, 3 insert mode;
//  higher indexes are ignored. Write configuration only while idle.
//  One command is in flight at a time. After acceptance the command passes
//  the execute state, any tab scan or stop-memory rewrite and the finish
//  state before the first event is offered, and one event follows per cycle
//  while m_axis_tready is high. Tab and back-tab scan the tab-stop memory
//  one column at a time, a read state and a check state per column, since
//  the memory read is registered. Clear-all-tabs, reset-tabs and any change
//  of columns rewrite all MAX_COLS entries of the stop memory, during which
//  no command is accepted. After reset the same pass loads the default stops
//  before s_axis_tready rises. If the receiver stalls, the current event is
//  held and no new command is taken until the status item has gone.
`default_nettype none

module terminal_cursor_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // codepoint[20:0], char_width[22:21], arg_x[31:23], arg_y[38:32],
  // repeat_count[46:39], arg_value[78:47]
  input  wire logic [79:0] s_axis_tdata,
  // cmd[4:0]
  input  wire logic [4:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // row_index[5:0], col_index[13:6], cell_char[34:14], cell_width[36:35],
  // cell_attr[68:37], wrap_pending[69]
  output logic [71:0]      m_axis_tdata,
  // event_kind[2:0]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);
  import tcc_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned CNW = $clog2(MAX_COLS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned RNW = $clog2(MAX_ROWS + 1);
  localparam int unsigned SXW = ((CNW > 9) ? CNW : 9) + 2;
  localparam int unsigned SYW = ((RNW > 7) ? RNW : 7) + 2;

  localparam logic [2:0] ST_SWEEP   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_TAB_RD  = 3'd3;
  localparam logic [2:0] ST_TAB_CHK = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0]     state_q;
  logic [CNW-1:0] cols_q;
  logic [RNW-1:0] rows_q;
  logic           aw_q, ins_q;
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic           wrap_q, orig_q;
  logic [RW-1:0]  rt_q, rb_q;
  logic [31:0]    attr_q;
  logic [CW-1:0]  sv_col_q;
  logic [RW-1:0]  sv_row_q;
  logic [31:0]    sv_attr_q;
  logic           sv_orig_q;
  logic [7:0]     rem_q;
  logic           dir_back_q;
  logic [CW-1:0]  sw_q;
  logic           sw_patt_q, sw_cmd_q;
  logic [2:0]     n_q, idx_q;

  logic [4:0]        cmd_q;
  logic [20:0]       cp_q;
  logic [1:0]        cw_q;
  logic signed [8:0] ax_q;
  logic signed [6:0] ay_q;
  logic [7:0]        rc_q;
  logic [31:0]       av_q;

  ev_t buf_q [EV_DEPTH];

  logic           s_fire, m_fire, cfg_fire;
  logic [CW-1:0]  colsm1;
  logic [RW-1:0]  rowsm1;
  logic [CNW-1:0] cfg_cols;
  logic [RNW-1:0] cfg_rows;
  logic           cols_change, rows_change;

  logic          mem_we, mem_wdata, tab_bit;
  logic [CW-1:0] mem_waddr, mem_raddr;

  ev_t           pr_ev [EV_DEPTH];
  logic [3:0]    pr_n;
  logic [CW-1:0] pr_col;
  logic [RW-1:0] pr_row;
  logic          pr_wrap;
  logic [RW-1:0] reg_rt, reg_rb;
  ev_t           out_ev;

  function automatic logic signed [SXW-1:0] clx(input logic signed [SXW-1:0] v,
                                                 input logic signed [SXW-1:0] hi);
    if (v < 0) return '0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SYW-1:0] cly(input logic signed [SYW-1:0] v,
                                                 input logic signed [SYW-1:0] lo,
                                                 input logic signed [SYW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = 1'b1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  assign colsm1 = CW'(cols_q - CNW'(1));
  assign rowsm1 = RW'(rows_q - RNW'(1));

  always_comb begin
    if (cfg_data_i == 9'd0) begin
      cfg_cols = CNW'(1);
    end else if (32'(cfg_data_i) > MAX_COLS) begin
      cfg_cols = CNW'(MAX_COLS);
    end else begin
      cfg_cols = CNW'(cfg_data_i);
    end
    if (cfg_data_i[6:0] == 7'd0) begin
      cfg_rows = RNW'(1);
    end else if (32'(cfg_data_i[6:0]) > MAX_ROWS) begin
      cfg_rows = RNW'(MAX_ROWS);
    end else begin
      cfg_rows = RNW'(cfg_data_i[6:0]);
    end
  end

  assign cols_change = cfg_fire && (cfg_index_i == CFG_COLUMNS) && (cfg_cols != cols_q);
  assign rows_change = cfg_fire && (cfg_index_i == CFG_ROWS) && (cfg_rows != rows_q);

  // print, line-feed and reverse line-feed events, computed in the execute cycle
  always_comb begin
    logic signed [SXW-1:0] x, wx, colsx;
    logic [RW-1:0]         y;
    logic                  wf;
    logic [1:0]            w;
    for (int i = 0; i < EV_DEPTH; i++) begin
      pr_ev[i] = '0;
    end
    pr_n  = '0;
    x     = $signed(SXW'(col_q));
    colsx = $signed(SXW'(cols_q));
    y     = row_q;
    wf    = wrap_q;
    w     = (cw_q == 2'd3) ? 2'd1 : cw_q;
    wx    = $signed(SXW'(w));
    case (cmd_q)
      CMD_PRINT: begin
        if (w != 2'd0) begin
          if (wf && aw_q) begin
            pr_ev[pr_n[2:0]] = mk_ev(EV_MARK, 6'(y), 8'd0, 21'd0, 2'd0);
            pr_n = pr_n + 4'd1;
            x  = '0;
            wf = 1'b0;
            if (y == rb_q) begin
              pr_ev[pr_n[2:0]] = mk_ev(EV_SCROLL_UP, 6'(rt_q), 8'(rb_q), 21'd0, 2'd0);
              pr_n = pr_n + 4'd1;
            end else if (y < rowsm1) begin
              y = y + RW'(1);
            end
          end
          if (x + wx > colsx) begin
            if (!aw_q) begin
              x = colsx - wx;
            end else begin
              pr_ev[pr_n[2:0]] = mk_ev(EV_MARK, 6'(y), 8'd0, 21'd0, 2'd0);
              pr_n = pr_n + 4'd1;
              x  = '0;
              wf = 1'b0;
              if (y == rb_q) begin
                pr_ev[pr_n[2:0]] = mk_ev(EV_SCROLL_UP, 6'(rt_q), 8'(rb_q), 21'd0, 2'd0);
                pr_n = pr_n + 4'd1;
              end else if (y < rowsm1) begin
                y = y + RW'(1);
              end
            end
          end
          if (x < 0) begin
            x = '0;
          end
          if (ins_q) begin
            pr_ev[pr_n[2:0]] = mk_ev(EV_INSERT, 6'(y), 8'(x), 21'd0, w);
            pr_n = pr_n + 4'd1;
          end
          pr_ev[pr_n[2:0]] = mk_ev(EV_CELL, 6'(y), 8'(x), cp_q, w);
          pr_n = pr_n + 4'd1;
          if (w == 2'd2 && x + SXW'(1) < colsx) begin
            pr_ev[pr_n[2:0]] = mk_ev(EV_TAIL, 6'(y), 8'(x + SXW'(1)), 21'd0, 2'd0);
            pr_n = pr_n + 4'd1;
          end
          x = x + wx;
          if (x >= colsx) begin
            x  = colsx - SXW'(1);
            wf = 1'b1;
          end
        end
      end
      CMD_LF: begin
        if (row_q == rb_q) begin
          pr_ev[0] = mk_ev(EV_SCROLL_UP, 6'(rt_q), 8'(rb_q), 21'd0, 2'd0);
          pr_n = 4'd1;
        end
      end
      CMD_RLF: begin
        if (row_q == rt_q) begin
          pr_ev[0] = mk_ev(EV_SCROLL_DN, 6'(rt_q), 8'(rb_q), 21'd0, 2'd0);
          pr_n = 4'd1;
        end
      end
      default: ;
    endcase
    pr_col  = CW'(x);
    pr_row  = y;
    pr_wrap = wf;
  end

  // scroll region command
  always_comb begin
    if (ax_q >= ay_q) begin
      reg_rt = '0;
      reg_rb = rowsm1;
    end else begin
      reg_rt = RW'(clx(SXW'(ax_q), $signed(SXW'(rowsm1))));
      reg_rb = RW'(cly(SYW'(ay_q), $signed(SYW'(reg_rt)), $signed(SYW'(rowsm1))));
    end
  end

  // tab memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = col_q;
    mem_wdata = 1'b0;
    mem_raddr = dir_back_q ? (col_q - CW'(1)) : (col_q + CW'(1));
    if (state_q == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sw_q;
      mem_wdata = sw_patt_q && ((sw_q % TAB_SPACING) == 0) && (sw_q != '0)
                  && (CNW'(sw_q) < cols_q);
    end else if (state_q == ST_EXEC && (cmd_q == CMD_SETTAB || cmd_q == CMD_CLRTAB)) begin
      mem_we    = 1'b1;
      mem_wdata = (cmd_q == CMD_SETTAB);
    end
  end

  tcc_tab_mem #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_tab_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (tab_bit)
  );

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q <= s_axis_tuser;
      cp_q  <= s_axis_tdata[20:0];
      cw_q  <= s_axis_tdata[22:21];
      ax_q  <= s_axis_tdata[31:23];
      ay_q  <= s_axis_tdata[38:32];
      rc_q  <= s_axis_tdata[46:39];
      av_q  <= s_axis_tdata[78:47];
    end
    if (state_q == ST_EXEC) begin
      for (int i = 0; i < EV_DEPTH; i++) begin
        buf_q[i] <= pr_ev[i];
      end
    end
    if (state_q == ST_FIN) begin
      buf_q[n_q] <= mk_ev(EV_STATUS, 6'(row_q), 8'(col_q), 21'd0, 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      cols_q     <= CNW'(80);
      rows_q     <= RNW'(24);
      aw_q       <= 1'b1;
      ins_q      <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      wrap_q     <= 1'b0;
      orig_q     <= 1'b0;
      rt_q       <= '0;
      rb_q       <= RW'(23);
      attr_q     <= '0;
      sv_col_q   <= '0;
      sv_row_q   <= '0;
      sv_attr_q  <= '0;
      sv_orig_q  <= 1'b0;
      rem_q      <= '0;
      dir_back_q <= 1'b0;
      sw_q       <= '0;
      sw_patt_q  <= 1'b1;
      sw_cmd_q   <= 1'b0;
      n_q        <= '0;
      idx_q      <= '0;
    end else begin
      case (state_q)
        ST_SWEEP: begin
          sw_q <= sw_q + CW'(1);
          if (sw_q == CW'(MAX_COLS - 1)) begin
            state_q  <= sw_cmd_q ? ST_FIN : ST_IDLE;
            sw_cmd_q <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          n_q     <= pr_n[2:0];
          state_q <= ST_FIN;
          case (cmd_q)
            CMD_PRINT: begin
              col_q  <= pr_col;
              row_q  <= pr_row;
              wrap_q <= pr_wrap;
            end
            CMD_CR: begin
              col_q  <= '0;
              wrap_q <= 1'b0;
            end
            CMD_LF: begin
              wrap_q <= 1'b0;
              if (row_q != rb_q && row_q < rowsm1) begin
                row_q <= row_q + RW'(1);
              end
            end
            CMD_RLF: begin
              wrap_q <= 1'b0;
              if (row_q != rt_q && row_q != '0) begin
                row_q <= row_q - RW'(1);
              end
            end
            CMD_BS: begin
              wrap_q <= 1'b0;
              if (col_q != '0) begin
                col_q <= col_q - CW'(1);
              end
            end
            CMD_TAB, CMD_BACKTAB: begin
              rem_q      <= (rc_q == 8'd0) ? 8'd1 : rc_q;
              dir_back_q <= (cmd_q == CMD_BACKTAB);
              if (cmd_q == CMD_TAB) begin
                wrap_q <= 1'b0;
              end
              state_q <= ST_TAB_RD;
            end
            CMD_SETTAB, CMD_CLRTAB: ;
            CMD_CLRALLTABS, CMD_RESETTABS: begin
              sw_q      <= '0;
              sw_patt_q <= (cmd_q == CMD_RESETTABS);
              sw_cmd_q  <= 1'b1;
              state_q   <= ST_SWEEP;
            end
            CMD_MOVETO, CMD_COL, CMD_ROW: begin
              wrap_q <= 1'b0;
              if (cmd_q != CMD_ROW) begin
                col_q <= CW'(clx(SXW'(ax_q), $signed(SXW'(colsm1))));
              end
              if (cmd_q != CMD_COL) begin
                row_q <= RW'(cly(SYW'(ay_q) + $signed(SYW'(orig_q ? rt_q : '0)),
                                 $signed(SYW'(orig_q ? rt_q : '0)),
                                 $signed(SYW'(orig_q ? rb_q : rowsm1))));
              end
            end
            CMD_MOVEBY: begin
              wrap_q <= 1'b0;
              col_q  <= CW'(clx($signed(SXW'(col_q)) + SXW'(ax_q), $signed(SXW'(colsm1))));
              row_q  <= RW'(cly($signed(SYW'(row_q)) + SYW'(ay_q),
                                $signed(SYW'((row_q >= rt_q) ? rt_q : '0)),
                                $signed(SYW'((row_q <= rb_q) ? rb_q : rowsm1))));
            end
            CMD_SAVE: begin
              sv_col_q  <= col_q;
              sv_row_q  <= row_q;
              sv_attr_q <= attr_q;
              sv_orig_q <= orig_q;
            end
            CMD_RESTORE: begin
              col_q  <= (sv_col_q > colsm1) ? colsm1 : sv_col_q;
              row_q  <= (sv_row_q > rowsm1) ? rowsm1 : sv_row_q;
              attr_q <= sv_attr_q;
              orig_q <= sv_orig_q;
              wrap_q <= 1'b0;
            end
            CMD_REGION: begin
              rt_q   <= reg_rt;
              rb_q   <= reg_rb;
              col_q  <= '0;
              row_q  <= orig_q ? reg_rt : '0;
              wrap_q <= 1'b0;
            end
            CMD_ORIGIN: orig_q <= av_q[0];
            CMD_ATTR:   attr_q <= av_q;
            default: ;
          endcase
        end
        ST_TAB_RD: begin
          if (dir_back_q) begin
            if (col_q <= CW'(1)) begin
              col_q   <= '0;
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_TAB_CHK;
            end
          end else if (CNW'(col_q) + CNW'(1) >= CNW'(colsm1)) begin
            col_q   <= colsm1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_TAB_CHK;
          end
        end
        ST_TAB_CHK: begin
          col_q   <= dir_back_q ? (col_q - CW'(1)) : (col_q + CW'(1));
          state_q <= ST_TAB_RD;
          if (tab_bit) begin
            rem_q <= rem_q - 8'd1;
            if (rem_q == 8'd1) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          idx_q   <= '0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_fire) begin
            if (out_ev.kind == EV_STATUS) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // configuration applies last; user writes only idle/sweeping, not enforced
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_COLUMNS: begin
            if (cols_change) begin
              cols_q <= cfg_cols;
              wrap_q <= 1'b0;
              if (CNW'(col_q) >= cfg_cols) begin
                col_q <= CW'(cfg_cols - CNW'(1));
              end
              sw_q      <= '0;
              sw_patt_q <= 1'b1;
              state_q   <= ST_SWEEP;
            end
          end
          CFG_ROWS: begin
            if (rows_change) begin
              rows_q <= cfg_rows;
              wrap_q <= 1'b0;
              if (RNW'(row_q) >= cfg_rows) begin
                row_q <= RW'(cfg_rows - RNW'(1));
              end
              rt_q <= '0;
              rb_q <= RW'(cfg_rows - RNW'(1));
            end
          end
          CFG_AUTO_WRAP: aw_q  <= cfg_data_i[0];
          CFG_INSERT:    ins_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign out_ev        = buf_q[idx_q];
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tuser  = out_ev.kind;
  assign m_axis_tlast  = (out_ev.kind == EV_STATUS);
  assign m_axis_tdata  = {2'b00, wrap_q, attr_q, out_ev.width, out_ev.ch,
                          out_ev.col, out_ev.row};

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_tab_mem.sv =====
// Tab-stop bit memory: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcc_tab_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o
);

  logic mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_checker.sv =====
// Port-level checks of the terminal cursor controller, bound to the top level.
// Depends on terminal_cursor_controller_assert.svh.
`default_nettype none

`include "terminal_cursor_controller_assert.svh"

module tcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // one command in flight
  `TCC_ASSERT_NEXT(a_one_cmd, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // events of one command leave back to back
  `TCC_ASSERT_NEXT(a_burst, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   m_axis_tvalid)
  // status closes the command
  `TCC_ASSERT_NEXT(a_close, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                   !m_axis_tvalid)
  // stalled event holds its kind
  `TCC_ASSERT_HOLD(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tuser)

endmodule

bind terminal_cursor_controller tcc_checker u_tcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
